@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/stbt_pkg.sv @@
// Types, codes and constants of the structured text byte tokenizer.
package stbt_pkg;

    localparam int NEST_DEPTH = 16;
    localparam int DEPTH_W    = 5;
    localparam int IDX_W      = $clog2(NEST_DEPTH);

    typedef enum logic [3:0] {
        ST_UNDEF        = 4'd0,
        ST_ASSIGN_START = 4'd1,
        ST_ASSIGN_OP    = 4'd2,
        ST_ASSIGN_END   = 4'd3,
        ST_IN_NUMBER    = 4'd4,
        ST_INTRO_STRING = 4'd5,
        ST_IN_STRING    = 4'd6,
        ST_TERM_STRING  = 4'd7,
        ST_ESCAPE       = 4'd8,
        ST_INTRO_STRUCT = 4'd9,
        ST_TERM_STRUCT  = 4'd10,
        ST_BINARY       = 4'd11
    } parse_state_t;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_ASSIGN_START = 4'd1,
        EV_ID_CHAR      = 4'd2,
        EV_ASSIGN_OP    = 4'd3,
        EV_VALUE_END    = 4'd4,
        EV_BINARY_INTRO = 4'd5,
        EV_STR_OPEN     = 4'd6,
        EV_STR_CHAR     = 4'd7,
        EV_ESCAPE       = 4'd8,
        EV_STR_CLOSE    = 4'd9,
        EV_NUM_CHAR     = 4'd10,
        EV_STRUCT_OPEN  = 4'd11,
        EV_STRUCT_CLOSE = 4'd12
    } evt_t;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_UNEXPECTED = 3'd1,
        ERR_EMPTY_ID   = 3'd2,
        ERR_LINK       = 3'd3,
        ERR_OVERFLOW   = 3'd4,
        ERR_UNBALANCED = 3'd5,
        ERR_HALTED     = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        TK_UNKNOWN = 2'd0,
        TK_IDENT   = 2'd1,
        TK_STRING  = 2'd2,
        TK_NUMBER  = 2'd3
    } token_kind_t;

    typedef enum logic [1:0] {
        VK_NULL   = 2'd0,
        VK_STRING = 2'd1,
        VK_NUMBER = 2'd2,
        VK_STRUCT = 2'd3
    } value_kind_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // One token result as it leaves the parser.
    typedef struct packed {
        evt_t                 evt;
        logic [7:0]           char_out;
        value_kind_t          value_kind;
        logic                 empty_struct;
        logic [DEPTH_W-1:0]   depth;
        err_t                 error_code;
    } tok_res_t;

    // Control escapes; bit 8 set when the byte is no control escape.
    function automatic logic [8:0] escape_char(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h62:   r = 9'h008;
            8'h66:   r = 9'h00c;
            8'h6e:   r = 9'h00a;
            8'h72:   r = 9'h00d;
            8'h74:   r = 9'h009;
            8'h76:   r = 9'h00b;
            default: r = 9'h100;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/structured_text_byte_tokenizer_top.sv @@
// Top level of the structured text byte tokenizer: stream ports and pipeline registers.
//
//  Channel   | Direction | Payload                                        | Handshake
//  s_*       | in        | tdata: data_byte                               | tvalid/tready
//  m_*       | out       | tuser: event_res; tdata: token fields (below)  | tvalid/tready
//
// A byte accepted from s_* waits in the input register until the parser step fires; it then
// passes through the parser decision logic into the result register, with m_tvalid high.
// A new byte is accepted every cycle while the output is not stalled; throughput is one
// item per clock, bounded by the single parser step that updates the tokenizer state.
// Reset is asynchronous and active low; it clears the valid flags of both pipeline stages
// and all parser state, including the per-level member flags.
// A stalled output holds the result register and, behind it, the input register;
// s_tready drops only when both are full and m_tready is low.
`include "assert_macros.svh"

module structured_text_byte_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] char_out, [9:8] value_kind, [10] empty_struct,
                                   // [15:11] depth, [18:16] error_code, [23:19] zero
    output logic [3:0]  m_tuser    // [3:0] event_res
);
    import stbt_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    tok_res_t   out_res_reg;
    tok_res_t   step_res;
    logic       advance;
    logic       in_take;

    // The parser step fires when a byte waits and the result register is free
    // or is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    stbt_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.evt;
    assign m_tdata  = {5'b0, out_res_reg.error_code, out_res_reg.depth,
                       out_res_reg.empty_struct, out_res_reg.value_kind,
                       out_res_reg.char_out};

    `ASSERT_NXT(a_step_fills_out, clk, rst_n, advance, out_valid_reg, "parser step lost its result")
    `ASSERT_NXT(a_stall_keeps_in, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg), "waiting byte dropped")
    `ASSERT_IMP(a_halt_flags, clk, rst_n, out_valid_reg && (out_res_reg.error_code != ERR_OK), out_res_reg.evt == EV_NONE, "error result carries an event")

endmodule

@@ hw/rtl/stbt_parser.sv @@
// Tokenizer state and the per-byte decision logic.
`include "assert_macros.svh"

module stbt_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    output stbt_pkg::tok_res_t res
);
    import stbt_pkg::*;

    parse_state_t          state_reg, state_next;
    logic                  id_empty_reg, id_empty_next;
    logic                  val_empty_reg, val_empty_next;
    token_kind_t           tk_reg, tk_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [NEST_DEPTH-1:0] seen_reg, seen_next;
    logic                  closed_empty_reg, closed_empty_next;
    logic                  halted_reg, halted_next;

    logic [DEPTH_W-1:0]    depth_m1;
    logic [IDX_W-1:0]      top_idx;
    logic                  is_space;
    logic                  skips;
    logic [8:0]            esc;
    evt_t                  ev;
    logic [7:0]            ch;
    value_kind_t           vk;
    logic                  es;
    err_t                  err;

    always_comb
    begin
        depth_m1 = depth_reg - DEPTH_W'(1);
        top_idx  = depth_m1[IDX_W-1:0];
        is_space = ((data_byte >= CH_TAB) && (data_byte <= CH_CR)) || (data_byte == CH_SPACE);
        skips    = !(state_reg inside {ST_INTRO_STRING, ST_IN_STRING, ST_ESCAPE, ST_BINARY});
        esc      = escape_char(data_byte);

        state_next        = state_reg;
        id_empty_next     = id_empty_reg;
        val_empty_next    = val_empty_reg;
        tk_next           = tk_reg;
        depth_next        = depth_reg;
        seen_next         = seen_reg;
        closed_empty_next = closed_empty_reg;
        halted_next       = halted_reg;
        ev  = EV_NONE;
        ch  = 8'h00;
        vk  = VK_NULL;
        es  = 1'b0;
        err = ERR_OK;

        if (halted_reg)
        begin
            err = ERR_HALTED;
        end
        else if (is_space && skips)
        begin
            ev = EV_NONE;
        end
        else
        begin
            unique case (state_reg)
                ST_UNDEF, ST_ASSIGN_END, ST_INTRO_STRUCT:
                begin
                    if (data_byte == CH_DOT)
                    begin
                        id_empty_next = 1'b1;
                        state_next    = ST_ASSIGN_START;
                        ev            = EV_ASSIGN_START;
                    end
                    else if (data_byte == CH_RBRACE && state_reg != ST_UNDEF)
                    begin
                        if (depth_reg == '0)
                        begin
                            err = ERR_UNBALANCED;
                        end
                        else
                        begin
                            // Remember emptiness for the value end that must follow.
                            es                = !seen_reg[top_idx];
                            closed_empty_next = !seen_reg[top_idx];
                            depth_next        = depth_m1;
                            state_next        = ST_TERM_STRUCT;
                            ev                = EV_STRUCT_CLOSE;
                        end
                    end
                    else
                    begin
                        err = ERR_UNEXPECTED;
                    end
                end
                ST_ASSIGN_START:
                begin
                    if (data_byte == CH_EQUAL)
                    begin
                        if (id_empty_reg)
                        begin
                            err = ERR_EMPTY_ID;
                        end
                        else
                        begin
                            val_empty_next = 1'b1;
                            tk_next        = TK_UNKNOWN;
                            if (depth_reg != '0)
                            begin
                                seen_next[top_idx] = 1'b1;
                            end
                            state_next = ST_ASSIGN_OP;
                            ev         = EV_ASSIGN_OP;
                        end
                    end
                    else if (data_byte == CH_NUL || data_byte == CH_DOT ||
                             data_byte == CH_SLASH || data_byte == CH_COMMA ||
                             data_byte == CH_RBRACK || data_byte == CH_SEMI)
                    begin
                        err = ERR_UNEXPECTED;
                    end
                    else
                    begin
                        if (tk_reg == TK_UNKNOWN)
                        begin
                            tk_next = TK_IDENT;
                        end
                        id_empty_next = 1'b0;
                        ev            = EV_ID_CHAR;
                        ch            = data_byte;
                    end
                end
                ST_ASSIGN_OP, ST_IN_NUMBER, ST_TERM_STRING, ST_TERM_STRUCT:
                begin
                    if (data_byte == CH_SEMI)
                    begin
                        // Value end: the kind comes from what the value saw.
                        if (val_empty_reg)
                        begin
                            val_empty_next = 1'b0;
                        end
                        else if (state_reg == ST_TERM_STRUCT)
                        begin
                            vk = closed_empty_reg ? VK_NULL : VK_STRUCT;
                        end
                        else if (tk_reg == TK_STRING)
                        begin
                            vk = VK_STRING;
                        end
                        else if (tk_reg == TK_NUMBER)
                        begin
                            vk = VK_NUMBER;
                        end
                        tk_next    = TK_UNKNOWN;
                        state_next = ST_ASSIGN_END;
                        ev         = EV_VALUE_END;
                    end
                    else if (state_reg == ST_ASSIGN_OP)
                    begin
                        if (data_byte == CH_NUL)
                        begin
                            val_empty_next = 1'b0;
                            state_next     = ST_BINARY;
                            ev             = EV_BINARY_INTRO;
                        end
                        else if (data_byte == CH_DQUOTE)
                        begin
                            state_next = ST_INTRO_STRING;
                            ev         = EV_STR_OPEN;
                        end
                        else if (data_byte == CH_LBRACE)
                        begin
                            if (depth_reg >= DEPTH_W'(NEST_DEPTH))
                            begin
                                err = ERR_OVERFLOW;
                            end
                            else
                            begin
                                val_empty_next = 1'b0;
                                depth_next     = depth_reg + DEPTH_W'(1);
                                seen_next[depth_reg[IDX_W-1:0]] = 1'b0;
                                state_next     = ST_INTRO_STRUCT;
                                ev             = EV_STRUCT_OPEN;
                            end
                        end
                        else if (data_byte == CH_DOT)
                        begin
                            err = ERR_LINK;
                        end
                        else if (data_byte == CH_MINUS || data_byte == CH_DOLLAR ||
                                 (data_byte >= CH_ZERO && data_byte <= CH_NINE))
                        begin
                            if (tk_reg == TK_UNKNOWN)
                            begin
                                val_empty_next = 1'b0;
                                tk_next        = TK_NUMBER;
                            end
                            state_next = ST_IN_NUMBER;
                            ev         = EV_NUM_CHAR;
                            ch         = data_byte;
                        end
                        else
                        begin
                            err = ERR_UNEXPECTED;
                        end
                    end
                    else if (state_reg == ST_IN_NUMBER)
                    begin
                        if (data_byte == CH_COMMA || data_byte == CH_RBRACK ||
                            data_byte == CH_NUL)
                        begin
                            err = ERR_UNEXPECTED;
                        end
                        else
                        begin
                            if (tk_reg == TK_UNKNOWN)
                            begin
                                val_empty_next = 1'b0;
                                tk_next        = TK_NUMBER;
                            end
                            ev = EV_NUM_CHAR;
                            ch = data_byte;
                        end
                    end
                    else if (state_reg == ST_TERM_STRING && data_byte == CH_DQUOTE)
                    begin
                        // Adjacent strings concatenate.
                        state_next = ST_INTRO_STRING;
                        ev         = EV_STR_OPEN;
                    end
                    else
                    begin
                        err = ERR_UNEXPECTED;
                    end
                end
                ST_INTRO_STRING, ST_IN_STRING:
                begin
                    if (data_byte == CH_NUL)
                    begin
                        err = ERR_UNEXPECTED;
                    end
                    else if (data_byte == CH_DQUOTE)
                    begin
                        state_next = ST_TERM_STRING;
                        ev         = EV_STR_CLOSE;
                    end
                    else if (data_byte == CH_BSLASH)
                    begin
                        state_next = ST_ESCAPE;
                        ev         = EV_ESCAPE;
                    end
                    else
                    begin
                        if (tk_reg == TK_UNKNOWN)
                        begin
                            val_empty_next = 1'b0;
                            tk_next        = TK_STRING;
                        end
                        state_next = ST_IN_STRING;
                        ev         = EV_STR_CHAR;
                        ch         = data_byte;
                    end
                end
                ST_ESCAPE:
                begin
                    if (data_byte == CH_BSLASH || data_byte == CH_DQUOTE)
                    begin
                        if (tk_reg == TK_UNKNOWN)
                        begin
                            val_empty_next = 1'b0;
                            tk_next        = TK_STRING;
                        end
                        state_next = ST_IN_STRING;
                        ev         = EV_STR_CHAR;
                        ch         = data_byte;
                    end
                    else if (!esc[8])
                    begin
                        // Control escapes do not mark the value as a string.
                        state_next = ST_IN_STRING;
                        ev         = EV_STR_CHAR;
                        ch         = esc[7:0];
                    end
                    else
                    begin
                        err = ERR_UNEXPECTED;
                    end
                end
                default:
                begin
                    err = ERR_UNEXPECTED;
                end
            endcase

            if (err != ERR_OK)
            begin
                // An error leaves all parse state as it was and halts.
                state_next        = state_reg;
                id_empty_next     = id_empty_reg;
                val_empty_next    = val_empty_reg;
                tk_next           = tk_reg;
                depth_next        = depth_reg;
                seen_next         = seen_reg;
                closed_empty_next = closed_empty_reg;
                halted_next       = 1'b1;
            end
        end

        if (err != ERR_OK)
        begin
            ev = EV_NONE;
            ch = 8'h00;
            vk = VK_NULL;
            es = 1'b0;
        end

        res.evt          = ev;
        res.char_out     = ch;
        res.value_kind   = vk;
        res.empty_struct = es;
        res.depth        = depth_next;
        res.error_code   = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_UNDEF;
            id_empty_reg     <= 1'b0;
            val_empty_reg    <= 1'b0;
            tk_reg           <= TK_UNKNOWN;
            depth_reg        <= '0;
            seen_reg         <= '0;
            closed_empty_reg <= 1'b0;
            halted_reg       <= 1'b0;
        end
        else if (advance)
        begin
            state_reg        <= state_next;
            id_empty_reg     <= id_empty_next;
            val_empty_reg    <= val_empty_next;
            tk_reg           <= tk_next;
            depth_reg        <= depth_next;
            seen_reg         <= seen_next;
            closed_empty_reg <= closed_empty_next;
            halted_reg       <= halted_next;
        end
    end

    `ASSERT_NXT(a_err_halts, clk, rst_n, advance && (res.error_code != ERR_OK), halted_reg, "error did not halt")
    `ASSERT_IMP(a_depth_range, clk, rst_n, 1'b1, depth_reg <= DEPTH_W'(NEST_DEPTH), "depth out of range")
    `ASSERT_NXT(a_open_depth, clk, rst_n, advance && (res.evt == EV_STRUCT_OPEN), depth_reg == $past(depth_reg) + DEPTH_W'(1), "open did not deepen")
    `ASSERT_NXT(a_idle_hold, clk, rst_n, !advance, $stable(depth_reg) && $stable(state_reg) && $stable(halted_reg), "state moved without a byte")

endmodule
